// ===== rtl/core/lcum_pkg.sv =====
// lcum_pkg: shared types and constants for the lbp code / uniform map block
// used by lcum_compare, lcum_map and lbp_code_uniform_map; no dependencies
package lcum_pkg;

  localparam int PIXEL_BITS    = 8;
  localparam int MAX_NEIGHBORS = 8;
  localparam int CODE_W        = MAX_NEIGHBORS;
  localparam int COUNT_W       = 4;
  localparam int IDX_W         = 8;
  localparam int IN_W          = (MAX_NEIGHBORS + 1) * PIXEL_BITS;
  localparam int OUT_W         = 2 * CODE_W;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic {
    REG_NEIGHBOR_COUNT = 1'b0,
    REG_UNIFORM_MODE   = 1'b1
  } reg_index_t;

  typedef struct packed {
    code_t raw_code;
    code_t mapped_code;
    logic  is_uniform;
  } lcum_result_t;

endpackage

// ===== rtl/core/lbp_code_uniform_map.sv =====
// lbp_code_uniform_map: top level, config registers and the two pipeline registers
// depends on lcum_pkg, lcum_compare, lcum_map
//
// usage:
//   s_* takes one neighborhood per request: a center sample and eight neighbors.
//   m_* returns one result per request: raw code, mapped code and the uniform flag.
//   cfg_* writes neighbor_count (index 0, 0 acts as 1, above 8 as 8) and
//   uniform_mode (index 1); write only while no request is in flight.
// path: an accepted request reaches m_tvalid through the input register,
//   the compare and map logic and the result register.
// throughput: one request per cycle while m_tready is high, set by the single-pass map logic.
// stall: when m_tready is low the result register holds and the input
//   register still takes one more request; s_tready falls once both are full.
// reset: rst clears both valid flags, neighbor_count returns to 8 and
//   uniform_mode to 0.
module lbp_code_uniform_map import lcum_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // center [7:0], neighbor_0 [15:8], ... neighbor_7 [71:64]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // raw_code [7:0], mapped_code [15:8]
  output logic [OUT_W-1:0] m_tdata,
  // is_uniform [0]
  output logic             m_tuser,
  input  logic             cfg_we,
  input  reg_index_t       cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  count_t          neighbor_count;
  logic            uniform_mode;
  count_t          p_eff;
  logic            in_valid;
  logic [IN_W-1:0] in_data;
  logic            out_valid;
  lcum_result_t    out_result;
  lcum_result_t    result;
  code_t           raw_code;
  pixel_t          neighbor [MAX_NEIGHBORS];
  logic            adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= count_t'(MAX_NEIGHBORS);
      uniform_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEIGHBOR_COUNT: neighbor_count <= cfg_data;
        REG_UNIFORM_MODE:   uniform_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate p into 1..MAX_NEIGHBORS
  always_comb begin
    if (neighbor_count == '0) begin
      p_eff = count_t'(1);
    end else if (neighbor_count > count_t'(MAX_NEIGHBORS)) begin
      p_eff = count_t'(MAX_NEIGHBORS);
    end else begin
      p_eff = neighbor_count;
    end
  end

  assign adv_out  = !out_valid || m_tready;
  assign s_tready = !in_valid || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv_out) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_data <= s_tdata;
    if (adv_out && in_valid) out_result <= result;
  end

  always_comb begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      neighbor[i] = in_data[(i+1)*PIXEL_BITS +: PIXEL_BITS];
    end
  end

  lcum_compare u_compare (
    .center   (in_data[PIXEL_BITS-1:0]),
    .neighbor (neighbor),
    .p_eff    (p_eff),
    .raw_code (raw_code)
  );

  lcum_map u_map (
    .raw_code     (raw_code),
    .p_eff        (p_eff),
    .uniform_mode (uniform_mode),
    .result       (result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.mapped_code, out_result.raw_code};
  assign m_tuser  = out_result.is_uniform;

endmodule

// ===== rtl/core/lcum_compare.sv =====
// lcum_compare: thresholds the used neighbors against the center to form the raw code
// depends on lcum_pkg
module lcum_compare import lcum_pkg::*; (
  input  pixel_t center,
  input  pixel_t neighbor [MAX_NEIGHBORS],
  input  count_t p_eff,
  output code_t  raw_code
);

  always_comb begin
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      raw_code[i] = (COUNT_W'(i) < p_eff) && (neighbor[i] >= center);
    end
  end

endmodule

// ===== rtl/core/lcum_map.sv =====
// lcum_map: circular transition count and u2 index of a p-bit code
// depends on lcum_pkg
module lcum_map import lcum_pkg::*; (
  input  code_t        raw_code,
  input  count_t       p_eff,
  input  logic         uniform_mode,
  output lcum_result_t result
);

  logic [CODE_W:0] mask_wide;
  code_t           mask;
  code_t           rot;
  code_t           diff;
  logic [3:0]      trans;
  logic            uni;
  code_t           top_run;
  code_t           inv_raw;
  logic [2:0]      hi;
  logic [2:0]      lo;
  logic [2:0]      run_lo;
  logic [3:0]      low_ones;
  logic [2:0]      p_m1;
  logic            top_set;
  logic [IDX_W-1:0] pp;
  logic [IDX_W-1:0] tri_hi;
  logic [IDX_W-1:0] tri_run;
  logic [IDX_W-1:0] idx;

  assign mask_wide = (CODE_W+1)'((CODE_W+1)'(1) << p_eff) - (CODE_W+1)'(1);
  assign mask      = mask_wide[CODE_W-1:0];
  assign p_m1      = 3'(p_eff - count_t'(1));
  assign rot       = ((raw_code << 1) | (raw_code >> p_m1)) & mask;
  assign diff      = (raw_code ^ rot) & mask;
  assign top_set   = raw_code[p_m1];
  assign inv_raw   = ~raw_code;
  // clear the run of ones that starts at bit 0
  assign top_run   = raw_code & (raw_code + code_t'(1));

  always_comb begin
    trans    = '0;
    hi       = '0;
    lo       = '0;
    run_lo   = '0;
    low_ones = 4'(CODE_W);
    for (int i = 0; i < CODE_W; i++) begin
      trans = trans + 4'(diff[i]);
    end
    for (int i = 0; i < CODE_W; i++) begin
      if (raw_code[i]) hi = 3'(i);
    end
    for (int i = CODE_W - 1; i >= 0; i--) begin
      if (raw_code[i]) lo = 3'(i);
      if (top_run[i]) run_lo = 3'(i);
      if (inv_raw[i]) low_ones = 4'(i);
    end
  end

  assign uni     = (trans <= 4'd2);
  assign pp      = IDX_W'(p_eff) * (IDX_W'(p_eff) - IDX_W'(1));
  assign tri_hi  = IDX_W'((IDX_W'(hi) * (IDX_W'(hi) + IDX_W'(1))) >> 1);
  assign tri_run = IDX_W'((IDX_W'(run_lo) * (IDX_W'(run_lo) + IDX_W'(1))) >> 1);

  // index = number of uniform codes below this one
  always_comb begin
    if (raw_code == '0) begin
      idx = '0;
    end else if (raw_code == mask) begin
      idx = pp + IDX_W'(1);
    end else if (top_set) begin
      // ones reach bit p-1: ordered by start of the top run, then low run length
      idx = pp + IDX_W'(1) - tri_run + IDX_W'(low_ones);
    end else begin
      idx = IDX_W'(1) + tri_hi + IDX_W'(hi) - IDX_W'(lo);
    end
  end

  always_comb begin
    result.raw_code   = raw_code;
    result.is_uniform = uni;
    if (!uniform_mode) begin
      result.mapped_code = raw_code;
    end else if (uni) begin
      result.mapped_code = code_t'(idx);
    end else begin
      result.mapped_code = code_t'(pp + IDX_W'(2));
    end
  end

endmodule

// ===== dv/lbp_code_uniform_map_checker.sv =====
// lbp_code_uniform_map_checker: watches the request, result and register ports,
// predicts each result and compares it; depends on lcum_pkg only
module lbp_code_uniform_map_checker import lcum_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic             m_tuser,
  input  logic             cfg_we,
  input  reg_index_t       cfg_index,
  input  logic [COUNT_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  count_t       nbr_count = count_t'(MAX_NEIGHBORS);
  logic         uni_mode  = 1'b0;
  lcum_result_t code_q[$];
  int           fail_cnt  = 0;

  // circular bit changes of the low p bits
  function automatic int unsigned ring_flips(code_t code, int unsigned p);
    int unsigned mask;
    int unsigned c;
    int unsigned rot;
    mask = (1 << p) - 1;
    c    = int'(code) & mask;
    rot  = ((c << 1) | (c >> (p - 1))) & mask;
    return $countones((c ^ rot) & mask);
  endfunction

  function automatic lcum_result_t lbp_expect(logic [IN_W-1:0] d, count_t cnt,
                                              logic umode);
    lcum_result_t r;
    int unsigned  p;
    int unsigned  idx;
    pixel_t       ctr;
    code_t        raw;
    logic         uni;
    p   = (cnt == 0) ? 1 : ((cnt > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(cnt));
    ctr = d[PIXEL_BITS-1:0];
    raw = '0;
    for (int i = 0; i < p; i++) begin
      if (d[PIXEL_BITS*(i+1) +: PIXEL_BITS] >= ctr) raw[i] = 1'b1;
    end
    uni = (ring_flips(raw, p) <= 2);
    r.raw_code   = raw;
    r.is_uniform = uni;
    if (!umode) begin
      r.mapped_code = raw;
    end else if (uni) begin
      // index = number of uniform codes below this one
      idx = 0;
      for (int k = 0; k < int'(raw); k++) begin
        if (ring_flips(code_t'(k), p) <= 2) idx++;
      end
      r.mapped_code = code_t'(idx);
    end else begin
      r.mapped_code = code_t'(p * (p - 1) + 2);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lcum_result_t want;
    lcum_result_t got;
    if (rst) begin
      code_q.delete();
      nbr_count = count_t'(MAX_NEIGHBORS);
      uni_mode  = 1'b0;
    end else begin
      // results first: a request accepted at this edge cannot be answered yet
      if (m_tvalid && m_tready) begin
        got.raw_code    = m_tdata[CODE_W-1:0];
        got.mapped_code = m_tdata[2*CODE_W-1:CODE_W];
        got.is_uniform  = m_tuser;
        if (code_q.size() == 0) begin
          $display("%0t: result with nothing expected, got raw %h mapped %h uniform %b",
                   $time, got.raw_code, got.mapped_code, got.is_uniform);
          fail_cnt++;
        end else begin
          want = code_q.pop_front();
          if (got.raw_code !== want.raw_code) begin
            $display("%0t: raw_code expected %h actual %h", $time,
                     want.raw_code, got.raw_code);
            fail_cnt++;
          end
          if (got.mapped_code !== want.mapped_code) begin
            $display("%0t: mapped_code expected %h actual %h", $time,
                     want.mapped_code, got.mapped_code);
            fail_cnt++;
          end
          if (got.is_uniform !== want.is_uniform) begin
            $display("%0t: is_uniform expected %b actual %b", $time,
                     want.is_uniform, got.is_uniform);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        code_q.insert(code_q.size(), lbp_expect(s_tdata, nbr_count, uni_mode));
      end
      if (cfg_we) begin
        if (cfg_index == REG_NEIGHBOR_COUNT) nbr_count = cfg_data;
        else if (cfg_index == REG_UNIFORM_MODE) uni_mode = cfg_data[0];
      end
    end
    pending <= code_q.size();
    errors  <= fail_cnt;
  end

endmodule

// ===== dv/tb_lbp_code_uniform_map.sv =====
// tb_lbp_code_uniform_map: clock, reset, request and register stimulus, result
// back-pressure and verdict; depends on lcum_pkg, the block and the checker
module tb_lbp_code_uniform_map;
  import lcum_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_CYCLES = 64;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;
  logic              cfg_we    = 1'b0;
  reg_index_t        cfg_index = REG_NEIGHBOR_COUNT;
  logic [COUNT_W-1:0] cfg_data = '0;
  int                errors;
  int                pending;

  int                burst_left   = 1;
  logic              steady       = 1'b0;
  int                hold_req_cnt = 0;

  lbp_code_uniform_map i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbp_code_uniform_map_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // neighborhood whose comparisons give the wanted code (center 0 forces ones)
  function automatic logic [IN_W-1:0] item_for_code(code_t code, pixel_t center);
    logic [IN_W-1:0] d;
    pixel_t          nb;
    d = '0;
    d[PIXEL_BITS-1:0] = center;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      if (code[i] || center == 0) begin
        if ($urandom_range(0, 3) == 0) nb = center;
        else nb = pixel_t'($urandom_range(int'(center), 255));
      end else begin
        nb = pixel_t'($urandom_range(0, int'(center) - 1));
      end
      d[PIXEL_BITS*(i+1) +: PIXEL_BITS] = nb;
    end
    return d;
  endfunction

  // one run of ones rotated around the p-bit ring, random bits above p
  function automatic code_t ring_run(int unsigned p);
    int unsigned len;
    int unsigned rot;
    int unsigned run;
    int unsigned mask;
    len  = $urandom_range(0, p);
    rot  = $urandom_range(0, p - 1);
    mask = (1 << p) - 1;
    run  = (1 << len) - 1;
    run  = ((run << rot) | (run >> (p - rot))) & mask;
    return code_t'(($urandom & ~mask) | run);
  endfunction

  function automatic logic [IN_W-1:0] random_item(int unsigned p);
    int unsigned pick;
    logic [IN_W-1:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      d = item_for_code(ring_run(p), pixel_t'($urandom_range(1, 254)));
    end else if (pick < 75) begin
      d = item_for_code(code_t'($urandom), pixel_t'($urandom));
    end else begin
      for (int i = 0; i <= MAX_NEIGHBORS; i++) begin
        d[PIXEL_BITS*i +: PIXEL_BITS] = pixel_t'($urandom);
      end
    end
    return d;
  endfunction

  function automatic logic [IN_W-1:0] flat_item(pixel_t center, pixel_t nb);
    logic [IN_W-1:0] d;
    d[PIXEL_BITS-1:0] = center;
    for (int i = 1; i <= MAX_NEIGHBORS; i++) d[PIXEL_BITS*i +: PIXEL_BITS] = nb;
    return d;
  endfunction

  task automatic send_item(input logic [IN_W-1:0] d);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady) begin
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // the checker's count is registered, so wait for a clock edge before looking at it
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input count_t cnt, input logic umode);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NEIGHBOR_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    cfg_index <= REG_UNIFORM_MODE;
    cfg_data  <= {{(COUNT_W-1){1'b0}}, umode};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: stretches of varying stall density, plus long hold-offs on request
  initial begin : result_side
    int stall_pct;
    int stretch_left;
    int hold_seen;
    stall_pct    = 0;
    stretch_left = 0;
    hold_seen    = 0;
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
          stretch_left = $urandom_range(10, 80);
        end
        stretch_left--;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    count_t      cnt;
    logic        umode;
    int unsigned eff;
    code_t       dir_codes[12];
    dir_codes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h81, 8'h0F,
                  8'hF0, 8'h55, 8'hAA, 8'h7F, 8'h3C, 8'hC3};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: field extremes and the equal-to-center boundary
    send_item(flat_item(8'h00, 8'h00));
    send_item(flat_item(8'hFF, 8'hFF));
    send_item(flat_item(8'hFF, 8'hFE));
    send_item(flat_item(8'h00, 8'hFF));
    send_item(flat_item(8'h80, 8'h7F));
    drain_results();

    // full ring with mapping: uniform runs, alternating and broken patterns
    write_regs(count_t'(8), 1'b1);
    foreach (dir_codes[i]) send_item(item_for_code(dir_codes[i], pixel_t'($urandom_range(1, 254))));
    drain_results();

    // single neighbor, upper neighbors must be ignored
    write_regs(count_t'(1), 1'b1);
    send_item(item_for_code(8'hFE, 8'h40));
    send_item(item_for_code(8'h01, 8'h40));
    drain_results();

    // counts out of range saturate
    write_regs(count_t'(0), 1'b1);
    send_item(item_for_code(8'h5B, 8'h90));
    drain_results();
    write_regs(count_t'(15), 1'b1);
    send_item(item_for_code(8'h6D, 8'h20));
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin cnt = count_t'(8);  umode = 1'b0; end
        1: begin cnt = count_t'(1);  umode = 1'b0; end
        2: begin cnt = count_t'(3);  umode = 1'b1; end
        3: begin cnt = count_t'(8);  umode = 1'b1; end
        4: begin cnt = count_t'(9);  umode = 1'b0; end
        5: begin cnt = count_t'(0);  umode = 1'b0; end
        default: begin
          cnt   = count_t'($urandom_range(0, 15));
          umode = 1'($urandom_range(0, 1));
        end
      endcase
      write_regs(cnt, umode);
      eff    = (cnt == 0) ? 1 : ((cnt > MAX_NEIGHBORS) ? MAX_NEIGHBORS : int'(cnt));
      steady = (ph % 4 == 3);
      if (ph == 3 || ph == 7) hold_req_cnt <= hold_req_cnt + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(eff));
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
